// ===== rtl/edge_interval_capture_macros.svh =====
// assertion macros shared by the edge interval capture rtl
// no dependencies; included inside module bodies
`ifndef EDGE_INTERVAL_CAPTURE_MACROS_SVH
`define EDGE_INTERVAL_CAPTURE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define EIC_ASSERT_NOW(label, clock, resetn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error("edge_interval_capture: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define EIC_ASSERT_NXT(label, clock, resetn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error("edge_interval_capture: next-cycle check failed");

`endif

// ===== rtl/eic_pkg.sv =====
// types and codes for the edge interval capture block
// no dependencies
package eic_pkg;

  localparam int OP_W   = 2;
  localparam int CH_W   = 3;
  localparam int MODE_W = 3;
  localparam int ST_W   = 2;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 24;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [ST_W-1:0]   status_t;

  localparam op_t OP_ARM  = 2'd0;
  localparam op_t OP_EDGE = 2'd1;
  localparam op_t OP_READ = 2'd2;

  localparam mode_t MODE_RISE_RISE = 3'd0;
  localparam mode_t MODE_FALL_FALL = 3'd1;
  localparam mode_t MODE_ANY_EDGE  = 3'd2;
  localparam mode_t MODE_HIGH_TIME = 3'd3;
  localparam mode_t MODE_LOW_TIME  = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_IGNORED  = 2'd1;
  localparam status_t ST_RESERVED = 2'd2;

  // control part of a request held in the input register
  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic            level;
  } req_t;

endpackage

// ===== rtl/edge_interval_capture.sv =====
// edge interval capture top level: per-channel edge timing state and handshakes
// depends on eic_pkg and edge_interval_capture_macros.svh

// Multi-channel input capture timer. Each request arms a channel, reports an
// edge with the pin level after it, or reads the channel's period, high time
// or low time as picked by its three mode bits in cfg_wdata. One request is
// taken every clock cycle unless in_stall is high; a taken request passes
// through the input register, then the result register, to the outputs.
// The whole update of the addressed channel - one or two timestamp subtractions
// and the register writes - is done in one pass between the two registers, so
// each request sees the state left by the one before it. in_stall is only
// raised while a held result is stalled and the input register is full.
// Time state is kept at the narrower of TIME_BITS and 32 bits and wraps.
module edge_interval_capture #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [eic_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [eic_pkg::OP_W-1:0]         in_operation,
  input  logic [eic_pkg::CH_W-1:0]         in_channel,
  input  logic                             in_pin_level,
  input  logic [eic_pkg::DATA_W-1:0]       in_now_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [eic_pkg::DATA_W-1:0] out_measured_value,
  output logic [eic_pkg::DATA_W-1:0]       out_edge_count,
  output logic [eic_pkg::ST_W-1:0]         out_status
);
  import eic_pkg::*;
  `include "edge_interval_capture_macros.svh"

  localparam int TW    = (TIME_BITS < DATA_W) ? TIME_BITS : DATA_W;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [CFG_W-1:0] modes_r;

  // per-channel state
  logic              active_r    [CHANNELS];
  logic [TW-1:0]     last_edge_r [CHANNELS];
  logic [TW-1:0]     last_rise_r [CHANNELS];
  logic [TW-1:0]     last_fall_r [CHANNELS];
  logic [TW-1:0]     period_r    [CHANNELS];
  logic [TW-1:0]     high_r      [CHANNELS];
  logic [TW-1:0]     low_r       [CHANNELS];
  logic [DATA_W-1:0] edges_r     [CHANNELS];

  // input register
  logic          s1_valid_r;
  req_t          s1_req_r;
  logic [TW-1:0] s1_now_r;

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [DATA_W-1:0] out_count_r;
  status_t           out_status_r;

  logic s1_adv;
  logic in_take;

  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  mode_t            mode;
  logic             wr_en;

  logic              active_nxt;
  logic [TW-1:0]     last_edge_nxt;
  logic [TW-1:0]     last_rise_nxt;
  logic [TW-1:0]     last_fall_nxt;
  logic [TW-1:0]     period_nxt;
  logic [TW-1:0]     high_nxt;
  logic [TW-1:0]     low_nxt;
  logic [DATA_W-1:0] edges_nxt;

  logic [TW-1:0]     res_value;
  logic [DATA_W-1:0] res_count;
  status_t           res_status;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign idx   = IDX_W'(s1_req_r.ch);
  assign ch_ok = ({1'b0, s1_req_r.ch} < (CH_W + 1)'(CHANNELS < 8 ? CHANNELS : 8));
  assign mode  = modes_r[3 * s1_req_r.ch +: MODE_W];

  always_comb begin
    active_nxt    = active_r[idx];
    last_edge_nxt = last_edge_r[idx];
    last_rise_nxt = last_rise_r[idx];
    last_fall_nxt = last_fall_r[idx];
    period_nxt    = period_r[idx];
    high_nxt      = high_r[idx];
    low_nxt       = low_r[idx];
    edges_nxt     = edges_r[idx];
    res_value     = '0;
    res_count     = edges_r[idx];
    res_status    = ST_IGNORED;
    wr_en         = 1'b0;
    if (!ch_ok) begin
      res_count = '0;
    end else begin
      unique case (s1_req_r.op)
        OP_ARM: begin
          wr_en         = 1'b1;
          active_nxt    = 1'b1;
          edges_nxt     = '0;
          last_edge_nxt = s1_now_r;
          last_rise_nxt = s1_now_r;
          last_fall_nxt = s1_now_r;
          res_count     = '0;
          res_status    = ST_OK;
        end
        OP_EDGE: begin
          if (!active_r[idx]) begin
            res_status = ST_IGNORED;
          end else if (mode > MODE_LOW_TIME) begin
            res_status = ST_RESERVED;
          end else if ((mode == MODE_RISE_RISE && !s1_req_r.level) ||
                       (mode == MODE_FALL_FALL && s1_req_r.level)) begin
            res_status = ST_IGNORED;
          end else begin
            wr_en         = 1'b1;
            res_status    = ST_OK;
            period_nxt    = s1_now_r - last_edge_r[idx];
            last_edge_nxt = s1_now_r;
            // duty modes also stamp the level change and count it
            if (mode >= MODE_HIGH_TIME) begin
              if (s1_req_r.level) begin
                last_rise_nxt = s1_now_r;
                low_nxt       = s1_now_r - last_fall_r[idx];
              end else begin
                last_fall_nxt = s1_now_r;
                high_nxt      = s1_now_r - last_rise_r[idx];
              end
              edges_nxt = edges_r[idx] + DATA_W'(1);
              res_count = edges_nxt;
            end
          end
        end
        OP_READ: begin
          res_status = ST_OK;
          if (mode <= MODE_ANY_EDGE) begin
            res_value = period_r[idx];
          end else if (mode == MODE_HIGH_TIME) begin
            res_value = high_r[idx];
          end else if (mode == MODE_LOW_TIME) begin
            res_value = low_r[idx];
          end else begin
            res_status = ST_RESERVED;
          end
        end
        default: begin
          res_status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r <= '0;
    end else if (cfg_we) begin
      modes_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= '{op: in_operation, ch: in_channel, level: in_pin_level};
      s1_now_r <= TW'(in_now_us);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        active_r[i]    <= 1'b0;
        last_edge_r[i] <= '0;
        last_rise_r[i] <= '0;
        last_fall_r[i] <= '0;
        period_r[i]    <= '0;
        high_r[i]      <= '0;
        low_r[i]       <= '0;
        edges_r[i]     <= '0;
      end
    end else if (s1_adv && wr_en) begin
      active_r[idx]    <= active_nxt;
      last_edge_r[idx] <= last_edge_nxt;
      last_rise_r[idx] <= last_rise_nxt;
      last_fall_r[idx] <= last_fall_nxt;
      period_r[idx]    <= period_nxt;
      high_r[idx]      <= high_nxt;
      low_r[idx]       <= low_nxt;
      edges_r[idx]     <= edges_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r  <= DATA_W'(res_value);
      out_count_r  <= res_count;
      out_status_r <= res_status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_measured_value = signed'(out_value_r);
  assign out_edge_count     = out_count_r;
  assign out_status         = out_status_r;

  `EIC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_r)
  `EIC_ASSERT_NXT(a_adv_fills_output, clk, rst_n, s1_adv, out_valid_r)
  `EIC_ASSERT_NXT(a_arm_activates, clk, rst_n,
    s1_adv && ch_ok && s1_req_r.op == OP_ARM, active_r[$past(idx)])
  `EIC_ASSERT_NOW(a_reserved_reads_zero, clk, rst_n,
    out_valid_r && out_status_r == ST_RESERVED, out_value_r == '0)

endmodule
